@@ sv/ppp_pkg.sv @@
package ppp_pkg;

  // configuration register map
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned RegWidth = 64;
  localparam int unsigned IdxWidth = 3;

  typedef enum logic [IdxWidth-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } reg_idx_e;

  // reset values, identity camera with unit depth
  localparam logic [RegWidth-1:0] ResetRow0Cols01 = 64'd4096;
  localparam logic [RegWidth-1:0] ResetRow0Cols23 = 64'd0;
  localparam logic [RegWidth-1:0] ResetRow1Cols01 = 64'd4096 << 32;
  localparam logic [RegWidth-1:0] ResetRow1Cols23 = 64'd0;
  localparam logic [RegWidth-1:0] ResetRow2Cols01 = 64'd0;
  localparam logic [RegWidth-1:0] ResetRow2Cols23 = 64'd4096;

  localparam int unsigned DefCoordWidth = 32;
  localparam int unsigned DefCoefWidth  = 32;
  localparam int unsigned CoordFrac     = 16;
  localparam int unsigned OutFrac       = 8;
  // quotient bits kept before saturation
  localparam int unsigned QuoBits       = 33;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               depth_zero;
    logic               clipped;
  } pixel_t;

endpackage

@@ sv/pinhole_point_projection.sv @@
// Projects one world point per cycle through a 3x4 matrix held in the
// configuration registers and returns u = r0/s, v = r1/s in Q24.8. A new
// point may be started in every cycle (busy_o stays low); its result word
// appears on done_o and is held for one cycle only, as the receiver
// cannot stall. The pipeline runs multiply, sum, magnitude and range check
// stages, then the two restoring dividers, which retire one quotient bit per
// pipeline stage (33 stages), and an output stage. Write the matrix only
// while no point is in flight.
module pinhole_point_projection #(
  parameter int unsigned COORD_WIDTH = ppp_pkg::DefCoordWidth,
  parameter int unsigned COEF_WIDTH  = ppp_pkg::DefCoefWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ppp_pkg::point_t               point_i,
  output logic                          busy_o,
  output logic                          done_o,
  output ppp_pkg::pixel_t               result_o,
  input  logic                          cfg_we_i,
  input  logic [ppp_pkg::IdxWidth-1:0]  cfg_idx_i,
  input  logic [ppp_pkg::RegWidth-1:0]  cfg_data_i
);
  import ppp_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned EW  = COEF_WIDTH;
  localparam int unsigned PW  = CW + EW;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned RW  = SW + QuoBits + 1;
  localparam int unsigned LAT = QuoBits + 5;

  // configuration registers
  logic [RegWidth-1:0] cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ROW0_COLS01] <= ResetRow0Cols01;
      cfg_q[REG_ROW0_COLS23] <= ResetRow0Cols23;
      cfg_q[REG_ROW1_COLS01] <= ResetRow1Cols01;
      cfg_q[REG_ROW1_COLS23] <= ResetRow1Cols23;
      cfg_q[REG_ROW2_COLS01] <= ResetRow2Cols01;
      cfg_q[REG_ROW2_COLS23] <= ResetRow2Cols23;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROW0_COLS01: cfg_q[REG_ROW0_COLS01] <= cfg_data_i;
        REG_ROW0_COLS23: cfg_q[REG_ROW0_COLS23] <= cfg_data_i;
        REG_ROW1_COLS01: cfg_q[REG_ROW1_COLS01] <= cfg_data_i;
        REG_ROW1_COLS23: cfg_q[REG_ROW1_COLS23] <= cfg_data_i;
        REG_ROW2_COLS01: cfg_q[REG_ROW2_COLS01] <= cfg_data_i;
        REG_ROW2_COLS23: cfg_q[REG_ROW2_COLS23] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // matrix entries, low bits of each 32-bit half
  logic signed [EW-1:0] coef [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = cfg_q[r*2 + c/2][(c%2)*32 +: EW];
      end
    end
  end

  assign busy_o = 1'b0;

  // point coordinates at the internal width
  logic signed [CW-1:0] pt [3];
  assign pt[0] = CW'(point_i.point_x);
  assign pt[1] = CW'(point_i.point_y);
  assign pt[2] = CW'(point_i.point_z);

  // stage 1: nine products and three scaled offsets
  logic                 s1_vld_q;
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [PW-1:0] off_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= PW'(coef[r][c]) * PW'(pt[c]);
        end
        off_q[r] <= PW'(coef[r][3]) <<< CoordFrac;
      end
    end
  end

  // stage 2: row sums
  logic                 s2_vld_q;
  logic signed [SW-1:0] sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1])
                  + SW'(prod_q[r][2]) + SW'(off_q[r]);
      end
    end
  end

  // stage 3: signs and magnitudes, numerators scaled to the output fraction
  logic          s3_vld_q;
  logic          s3_dz_q;
  logic [1:0]    s3_neg_q;
  logic [RW-1:0] s3_num_q [2];
  logic [RW-1:0] s3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
      s3_dz_q  <= (sum_q[2] == '0);
      s3_den_q <= sum_q[2][SW-1] ? RW'(-RW'(sum_q[2])) : RW'(sum_q[2]);
      for (int c = 0; c < 2; c++) begin
        s3_neg_q[c] <= sum_q[c][SW-1] ^ sum_q[2][SW-1];
        s3_num_q[c] <= (sum_q[c][SW-1] ? RW'(-RW'(sum_q[c])) : RW'(sum_q[c]))
                       << OutFrac;
      end
    end
  end

  // stage 4: quotient range check
  logic          dv_vld_q [QuoBits+1];
  logic          dv_dz_q  [QuoBits+1];
  logic [1:0]    dv_neg_q [QuoBits+1];
  logic [1:0]    dv_ovf_q [QuoBits+1];
  logic [RW-1:0] dv_den_q [QuoBits+1];
  logic [RW-1:0] dv_rem_q [QuoBits+1][2];
  logic [QuoBits-1:0] dv_quo_q [QuoBits+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= s3_vld_q;
      dv_dz_q[0]  <= s3_dz_q;
      dv_neg_q[0] <= s3_neg_q;
      dv_den_q[0] <= s3_den_q;
      for (int c = 0; c < 2; c++) begin
        dv_ovf_q[0][c] <= s3_num_q[c] >= (s3_den_q << QuoBits);
        dv_rem_q[0][c] <= s3_num_q[c];
        dv_quo_q[0][c] <= '0;
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int unsigned Bit = QuoBits - 1 - k;
    logic [RW-1:0] dsh;
    assign dsh = dv_den_q[k] << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
        dv_dz_q[k+1]  <= dv_dz_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_ovf_q[k+1] <= dv_ovf_q[k];
        dv_den_q[k+1] <= dv_den_q[k];
        for (int c = 0; c < 2; c++) begin
          if (dv_rem_q[k][c] >= dsh) begin
            dv_rem_q[k+1][c] <= dv_rem_q[k][c] - dsh;
            dv_quo_q[k+1][c] <= dv_quo_q[k][c] | (QuoBits'(1) << Bit);
          end else begin
            dv_rem_q[k+1][c] <= dv_rem_q[k][c];
            dv_quo_q[k+1][c] <= dv_quo_q[k][c];
          end
        end
      end
    end
  end

  // output stage: sign, saturation, zero depth
  localparam logic [QuoBits-1:0] PosMax = QuoBits'(32'h7FFF_FFFF);
  localparam logic [QuoBits-1:0] NegMax = QuoBits'(32'h8000_0000);

  logic [31:0] pix [2];
  logic [1:0]  sat;
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (!dv_neg_q[QuoBits][c]) begin
        sat[c] = dv_ovf_q[QuoBits][c] || (dv_quo_q[QuoBits][c] > PosMax);
        pix[c] = sat[c] ? 32'h7FFF_FFFF : dv_quo_q[QuoBits][c][31:0];
      end else begin
        sat[c] = dv_ovf_q[QuoBits][c] || (dv_quo_q[QuoBits][c] > NegMax);
        pix[c] = sat[c] ? 32'h8000_0000 : 32'(-dv_quo_q[QuoBits][c][31:0]);
      end
    end
  end

  logic   out_vld_q;
  pixel_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld_q[QuoBits];
      if (dv_dz_q[QuoBits]) begin
        out_q.pixel_u    <= '0;
        out_q.pixel_v    <= '0;
        out_q.depth_zero <= 1'b1;
        out_q.clipped    <= 1'b0;
      end else begin
        out_q.pixel_u    <= pix[0];
        out_q.pixel_v    <= pix[1];
        out_q.depth_zero <= 1'b0;
        out_q.clipped    <= |sat;
      end
    end
  end

  assign done_o   = out_vld_q;
  assign result_o = out_q;

  // every result word matches an earlier start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result word without a matching start");

  // zero depth never reports clipping and gives zero pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.depth_zero) |->
      (!result_o.clipped && result_o.pixel_u == 0 && result_o.pixel_v == 0))
    else $error("zero depth word malformed");

  // the final remainder stays below the denominator unless overflow was flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[QuoBits] && !dv_dz_q[QuoBits]) |->
      (dv_rem_q[QuoBits][0] < dv_den_q[QuoBits] || dv_ovf_q[QuoBits][0]))
    else $error("divider remainder out of range");

endmodule
